[rtl/lpt_pkg.sv]
// ----------------------------------------------------------------------------
// Landing pad tracker package
// Shared types, codes and constants of the tracker's lanes, merge stage and
// top level.
// ----------------------------------------------------------------------------
package lpt_pkg;

   // Item operation codes.
   localparam logic [1:0] OP_VISION   = 2'd0;
   localparam logic [1:0] OP_POSITION = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;
   localparam logic [1:0] OP_START    = 2'd3;

   // Command modes.
   localparam logic [1:0] MODE_MOVE   = 2'd0;
   localparam logic [1:0] MODE_HOLD   = 2'd1;
   localparam logic [1:0] MODE_DISARM = 2'd2;

   // Register indexes on the configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_ADDR_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] REG_DETECT_THRESHOLD   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DISTANCE_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PAD_HEIGHT         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_EAST          = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_NORTH         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_UP            = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_MOVING_TARGET      = 3'd6;

   // Axis numbering of the lanes.
   localparam int AXES       = 3;
   localparam int AXIS_EAST  = 0;
   localparam int AXIS_NORTH = 1;
   localparam int AXIS_UP    = 2;

   // Q16.16 constants.
   localparam logic signed [31:0] LOW_HEIGHT_Q = 32'sd19661;   // 0.3 m
   localparam logic signed [32:0] BIAS_Q       = 33'sd6554;    // 0.1 m

   // Step arithmetic: step = floor((p + 655360) / 1310720), 1310720 = 5 * 2^18.
   localparam int PROD_W      = 55;
   localparam int STEP_SHIFT  = 18;
   localparam int DIV_W       = 40;
   localparam int DIV_DIGITS  = DIV_W / 4;
   localparam int DIV_CNT_W   = 4;
   localparam logic signed [PROD_W-1:0] HALF_STEP  = 55'sd655360;
   localparam logic signed [PROD_W-1:0] FEED_ROUND = 55'sd4295622656;  // 2^32 + 655360
   localparam logic [DIV_W-1:0]         DIV_BIAS   = 40'd171798691840; // 5 * 2^35
   localparam logic signed [37:0]       QUO_OFFSET = 38'sd34359738368;  // 2^35

   typedef logic signed [31:0] coord_type;

   // Phase strobes from the sequencer to the lanes and the merge stage.
   typedef struct packed {
      logic prep;
      logic mul;
      logic rnd;
      logic load;
      logic shift;
      logic fin;
   } lane_ctl_type;

   typedef struct packed {
      logic [3:0] digit;
      logic [2:0] rem;
   } div5_type;

   // One radix-16 digit of a long division by five.
   function automatic div5_type div5_digit(input logic [6:0] value);
      div5_type   res;
      logic [6:0] acc;
      acc = value;
      for (int k = 3; k >= 0; k--) begin
         if (acc >= (7'd5 << k)) begin
            acc          = acc - (7'd5 << k);
            res.digit[k] = 1'b1;
         end else begin
            res.digit[k] = 1'b0;
         end
      end
      res.rem = acc[2:0];
      return res;
   endfunction

endpackage

[rtl/lpt_lane.sv]
// ----------------------------------------------------------------------------
// Landing pad tracker axis lane
// Squares one offset and works out the new setpoint of one axis.
// ----------------------------------------------------------------------------
module lpt_lane (
   input  logic                 clock,
   input  lpt_pkg::lane_ctl_type ctl,
   input  lpt_pkg::coord_type   err,
   input  logic [20:0]          gain,
   input  logic                 feed,
   input  lpt_pkg::coord_type   prev,
   output logic [63:0]          square,
   output lpt_pkg::coord_type   setpoint
);

   logic signed [32:0]                 term_ff, term_in;
   logic                               feed_ff;
   logic [63:0]                        sq_ff, sq_in;
   logic signed [lpt_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [lpt_pkg::PROD_W-1:0]  num_ff, num_in;
   logic [lpt_pkg::DIV_W-1:0]          div_ff, div_in;
   logic [lpt_pkg::DIV_W-1:0]          quo_ff, quo_in;
   logic [2:0]                         rem_ff, rem_in;
   lpt_pkg::coord_type                 set_ff, set_in;
   lpt_pkg::div5_type                  digit;
   logic signed [37:0]                 step;
   logic signed [38:0]                 total;

   assign term_in = 33'(err) + (feed ? lpt_pkg::BIAS_Q : 33'sd0);
   assign sq_in   = $unsigned(64'(err) * 64'(err));
   assign prod_in = lpt_pkg::PROD_W'($signed({1'b0, gain})) * lpt_pkg::PROD_W'(term_ff);
   assign num_in  = prod_ff + (feed_ff ? lpt_pkg::FEED_ROUND : lpt_pkg::HALF_STEP);

   // The long division by five runs on a biased, non-negative dividend, so that
   // the quotient rounds towards minus infinity for negative steps as well.
   always_comb begin
      digit  = lpt_pkg::div5_digit({rem_ff, div_ff[lpt_pkg::DIV_W-1 -: 4]});
      div_in = {div_ff[lpt_pkg::DIV_W-5:0], 4'd0};
      quo_in = {quo_ff[lpt_pkg::DIV_W-5:0], digit.digit};
      rem_in = digit.rem;
      if (ctl.load) begin
         div_in = lpt_pkg::DIV_W'($signed(num_ff[lpt_pkg::PROD_W-1:lpt_pkg::STEP_SHIFT]))
                  + lpt_pkg::DIV_BIAS;
         quo_in = '0;
         rem_in = 3'd0;
      end
   end

   always_comb begin
      step  = $signed({1'b0, quo_ff[36:0]}) - lpt_pkg::QUO_OFFSET;
      total = 39'(step) + 39'(prev);
      if (total[38] != total[37] || total[37] != total[36] || total[36] != total[35]
          || total[35] != total[34] || total[34] != total[33] || total[33] != total[32]
          || total[32] != total[31]) begin
         set_in = total[38] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         set_in = total[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.prep) begin
         term_ff <= term_in;
         feed_ff <= feed;
      end
      if (ctl.mul) begin
         sq_ff   <= sq_in;
         prod_ff <= prod_in;
      end
      if (ctl.rnd) begin
         num_ff <= num_in;
      end
      if (ctl.load || ctl.shift) begin
         div_ff <= div_in;
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (ctl.fin) begin
         set_ff <= set_in;
      end
   end

   assign square   = sq_ff;
   assign setpoint = set_ff;

endmodule

[rtl/lpt_merge.sv]
// ----------------------------------------------------------------------------
// Landing pad tracker merge stage
// Combines the lanes' squares into the distance test and picks the mode.
// ----------------------------------------------------------------------------
module lpt_merge (
   input  logic                  clock,
   input  lpt_pkg::lane_ctl_type ctl,
   input  logic [63:0]           sq_east,
   input  logic [63:0]           sq_north,
   input  logic [63:0]           sq_up,
   input  logic [30:0]           threshold,
   input  lpt_pkg::coord_type    up_offset,
   input  logic                  pad_seen,
   output logic [1:0]            mode
);

   logic [61:0] t2_ff, t2_in;
   logic [63:0] sum_ff, sum_in;
   logic [1:0]  mode_ff, mode_in;
   logic        near, low;

   assign t2_in  = 62'(threshold) * 62'(threshold);
   assign sum_in = sq_east + sq_north + sq_up;

   // The sum of three squares stays below 2^64, so the compare is exact.
   assign near = sum_ff < {2'b00, t2_ff};
   assign low  = (up_offset < lpt_pkg::LOW_HEIGHT_Q) && (up_offset > -lpt_pkg::LOW_HEIGHT_Q);

   always_comb begin
      if (near) begin
         mode_in = lpt_pkg::MODE_DISARM;
      end else if (!pad_seen) begin
         mode_in = lpt_pkg::MODE_HOLD;
      end else if (low) begin
         mode_in = lpt_pkg::MODE_DISARM;
      end else begin
         mode_in = lpt_pkg::MODE_MOVE;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         t2_ff <= t2_in;
      end
      if (ctl.rnd) begin
         sum_ff <= sum_in;
      end
      if (ctl.load) begin
         mode_ff <= mode_in;
      end
   end

   assign mode = mode_ff;

endmodule

[rtl/landing_pad_tracking_step_unit.sv]
// ----------------------------------------------------------------------------
// Landing pad tracking step unit
// Event-driven landing tracker: vision, position, start and tick words in,
// one command word out per tick.
// ----------------------------------------------------------------------------
// Vision, position and start words are taken one per cycle while the unit is
// idle and update the tracker's state at once. A tick word is worked on by
// three axis lanes side by side (east, north, up) and a merge stage, in order:
// forming the gain terms, the multipliers, rounding, loading the dividers, the
// radix-16 division by five in each lane over ten digits, the saturating add
// and the commit. The division by five is the longest of these steps. While a
// tick is in progress no further word is accepted; a finished command word
// waits in the output register, and other words are taken meanwhile.
module landing_pad_tracking_step_unit (
   input  logic                              clock,
   input  logic                              reset,
   // Input channel.
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_operation,
   input  logic                              req_detected,
   input  logic signed [31:0]                req_offset_east,
   input  logic signed [31:0]                req_offset_north,
   input  logic signed [31:0]                req_drone_east,
   input  logic signed [31:0]                req_drone_north,
   input  logic signed [31:0]                req_drone_up,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_mode,
   output logic signed [31:0]                rsp_ref_east,
   output logic signed [31:0]                rsp_ref_north,
   output logic signed [31:0]                rsp_ref_up,
   // Configuration port.
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lpt_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   // Sequencer states of a tick.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_RND  = 3'd3;
   localparam logic [2:0] ST_LOAD = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_SUM  = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   // Configuration registers.
   logic [15:0]        det_thr_ff;
   logic [30:0]        dist_thr_ff;
   lpt_pkg::coord_type pad_height_ff;
   logic [20:0]        gain_ff [lpt_pkg::AXES];
   logic               moving_ff;

   // Tracker state.
   logic [15:0]        hit_ff, hit_in;
   logic [15:0]        miss_ff, miss_in;
   logic               seen_ff, seen_in;
   lpt_pkg::coord_type pad_off_ff [lpt_pkg::AXES];
   lpt_pkg::coord_type pad_off_in [lpt_pkg::AXES];
   lpt_pkg::coord_type drone_ff [lpt_pkg::AXES];
   lpt_pkg::coord_type drone_in [lpt_pkg::AXES];
   lpt_pkg::coord_type prev_ff [lpt_pkg::AXES];
   lpt_pkg::coord_type prev_in [lpt_pkg::AXES];
   lpt_pkg::coord_type last_ff [lpt_pkg::AXES];
   lpt_pkg::coord_type last_in [lpt_pkg::AXES];

   // Sequencer and output register.
   logic [2:0]                      state_ff, state_in;
   logic [lpt_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      rsp_mode_ff, rsp_mode_in;

   logic                            accept;
   logic                            commit;
   logic                            csr_write;
   logic [lpt_pkg::CSR_INDEX_W-1:0] csr_index;
   logic signed [32:0]              up_diff;
   lpt_pkg::coord_type              up_sat;
   lpt_pkg::lane_ctl_type           lane_ctl;
   logic [63:0]                     lane_sq [lpt_pkg::AXES];
   lpt_pkg::coord_type              lane_set [lpt_pkg::AXES];
   logic [1:0]                      merge_mode;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   // The command word is committed only once the output register is free.
   assign commit    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // ------------------------------------------------------------------
   // Configuration port. Writes complete in the access cycle; reads are
   // served straight from the registers.
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[lpt_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      unique case (csr_index)
         lpt_pkg::REG_DETECT_THRESHOLD:   prdata = 32'(det_thr_ff);
         lpt_pkg::REG_DISTANCE_THRESHOLD: prdata = 32'(dist_thr_ff);
         lpt_pkg::REG_PAD_HEIGHT:         prdata = pad_height_ff;
         lpt_pkg::REG_GAIN_EAST:          prdata = 32'(gain_ff[lpt_pkg::AXIS_EAST]);
         lpt_pkg::REG_GAIN_NORTH:         prdata = 32'(gain_ff[lpt_pkg::AXIS_NORTH]);
         lpt_pkg::REG_GAIN_UP:            prdata = 32'(gain_ff[lpt_pkg::AXIS_UP]);
         lpt_pkg::REG_MOVING_TARGET:      prdata = 32'(moving_ff);
         default:                         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         det_thr_ff                   <= 16'd10;
         dist_thr_ff                  <= 31'd13107;
         pad_height_ff                <= 32'sd0;
         gain_ff[lpt_pkg::AXIS_EAST]  <= 21'd6554;
         gain_ff[lpt_pkg::AXIS_NORTH] <= 21'd6554;
         gain_ff[lpt_pkg::AXIS_UP]    <= 21'd6554;
         moving_ff                    <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            lpt_pkg::REG_DETECT_THRESHOLD:   det_thr_ff <= pwdata[15:0];
            lpt_pkg::REG_DISTANCE_THRESHOLD: dist_thr_ff <= pwdata[30:0];
            lpt_pkg::REG_PAD_HEIGHT:         pad_height_ff <= pwdata;
            lpt_pkg::REG_GAIN_EAST:          gain_ff[lpt_pkg::AXIS_EAST] <= pwdata[20:0];
            lpt_pkg::REG_GAIN_NORTH:         gain_ff[lpt_pkg::AXIS_NORTH] <= pwdata[20:0];
            lpt_pkg::REG_GAIN_UP:            gain_ff[lpt_pkg::AXIS_UP] <= pwdata[20:0];
            lpt_pkg::REG_MOVING_TARGET:      moving_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Vertical offset: pad height less drone height, saturated to 32 bits.
   // ------------------------------------------------------------------
   assign up_diff = 33'(pad_height_ff) - 33'(drone_ff[lpt_pkg::AXIS_UP]);
   always_comb begin
      if (up_diff[32] != up_diff[31]) begin
         up_sat = up_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         up_sat = up_diff[31:0];
      end
   end

   // ------------------------------------------------------------------
   // State update. Non-tick words act in the cycle they are accepted; a tick
   // writes its results back when the command word is committed.
   // ------------------------------------------------------------------
   always_comb begin
      hit_in     = hit_ff;
      miss_in    = miss_ff;
      seen_in    = seen_ff;
      pad_off_in = pad_off_ff;
      drone_in   = drone_ff;
      prev_in    = prev_ff;
      last_in    = last_ff;
      if (accept) begin
         case (req_operation)
            lpt_pkg::OP_VISION: begin
               pad_off_in[lpt_pkg::AXIS_EAST]  = req_offset_east;
               pad_off_in[lpt_pkg::AXIS_NORTH] = req_offset_north;
               pad_off_in[lpt_pkg::AXIS_UP]    = up_sat;
               // Both counters saturate at their full scale.
               if (req_detected) begin
                  hit_in  = (hit_ff != 16'hFFFF) ? hit_ff + 16'd1 : hit_ff;
                  miss_in = 16'd0;
               end else begin
                  hit_in  = 16'd0;
                  miss_in = (miss_ff != 16'hFFFF) ? miss_ff + 16'd1 : miss_ff;
               end
               if (miss_in > det_thr_ff) begin
                  seen_in = 1'b0;
               end
               if (hit_in > det_thr_ff) begin
                  seen_in = 1'b1;
               end
            end
            lpt_pkg::OP_POSITION: begin
               drone_in[lpt_pkg::AXIS_EAST]  = req_drone_east;
               drone_in[lpt_pkg::AXIS_NORTH] = req_drone_north;
               drone_in[lpt_pkg::AXIS_UP]    = req_drone_up;
            end
            lpt_pkg::OP_START: begin
               prev_in = drone_ff;
            end
            default: ;
         endcase
      end
      if (commit) begin
         if (merge_mode == lpt_pkg::MODE_MOVE) begin
            prev_in = lane_set;
            last_in = lane_set;
         end else if (merge_mode == lpt_pkg::MODE_HOLD) begin
            // A lost pad pins the previous setpoint to where the drone is.
            prev_in = drone_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tick sequencer.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_operation == lpt_pkg::OP_TICK) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_MUL;
         ST_MUL:  state_in = ST_RND;
         ST_RND:  state_in = ST_LOAD;
         ST_LOAD: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lpt_pkg::DIV_CNT_W'(lpt_pkg::DIV_DIGITS - 1)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: state_in = ST_DONE;
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign lane_ctl.prep  = (state_ff == ST_PREP);
   assign lane_ctl.mul   = (state_ff == ST_MUL);
   assign lane_ctl.rnd   = (state_ff == ST_RND);
   assign lane_ctl.load  = (state_ff == ST_LOAD);
   assign lane_ctl.shift = (state_ff == ST_DIV);
   assign lane_ctl.fin   = (state_ff == ST_SUM);

   // ------------------------------------------------------------------
   // Output register. The reference fields come straight from the last
   // reference, which only a committed move can change, and a commit waits
   // until the previous word has been taken.
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_mode_in  = rsp_mode_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_mode_in  = merge_mode;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 16'd0;
         miss_ff      <= 16'd0;
         seen_ff      <= 1'b0;
         for (int i = 0; i < lpt_pkg::AXES; i++) begin
            pad_off_ff[i] <= 32'sd0;
            drone_ff[i]   <= 32'sd0;
            prev_ff[i]    <= 32'sd0;
            last_ff[i]    <= 32'sd0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         seen_ff      <= seen_in;
         pad_off_ff   <= pad_off_in;
         drone_ff     <= drone_in;
         prev_ff      <= prev_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_mode_ff <= rsp_mode_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mode      = rsp_mode_ff;
   assign rsp_ref_east  = last_ff[lpt_pkg::AXIS_EAST];
   assign rsp_ref_north = last_ff[lpt_pkg::AXIS_NORTH];
   assign rsp_ref_up    = last_ff[lpt_pkg::AXIS_UP];

   // ------------------------------------------------------------------
   // Axis lanes. Only the east lane carries the moving-target feed-forward.
   // ------------------------------------------------------------------
   for (genvar g = 0; g < lpt_pkg::AXES; g++) begin : g_lane
      lpt_lane u_lane (
         .clock    (clock),
         .ctl      (lane_ctl),
         .err      (pad_off_ff[g]),
         .gain     (gain_ff[g]),
         .feed     (moving_ff && (g == lpt_pkg::AXIS_EAST)),
         .prev     (prev_ff[g]),
         .square   (lane_sq[g]),
         .setpoint (lane_set[g])
      );
   end

   lpt_merge u_merge (
      .clock     (clock),
      .ctl       (lane_ctl),
      .sq_east   (lane_sq[lpt_pkg::AXIS_EAST]),
      .sq_north  (lane_sq[lpt_pkg::AXIS_NORTH]),
      .sq_up     (lane_sq[lpt_pkg::AXIS_UP]),
      .threshold (dist_thr_ff),
      .up_offset (pad_off_ff[lpt_pkg::AXIS_UP]),
      .pad_seen  (seen_ff),
      .mode      (merge_mode)
   );

endmodule
